/* hw/rtl/rsfd_pkg.sv */
// Shared types, constants and helper functions for the serial frame decoder.
// Used by the controller, the datapath and the top level; depends on nothing.
package rsfd_pkg;

	// Fixed field widths of the result beat.
	localparam int STATUS_W = 2;
	localparam int INDEX_W  = 5;
	localparam int VALUE_W  = 13;
	localparam int COUNT_W  = 6;
	localparam int FRAMES_W = 8;
	localparam int QUAL_W   = 7;
	localparam int BCNT_W   = 7;

	// Protocol bytes.
	localparam logic [7:0] HDR_BYTE = 8'hA8;
	localparam logic [7:0] ID_CRC   = 8'h01;
	localparam logic [7:0] ID_SUM   = 8'h00;
	localparam logic [7:0] MIN_COUNT = 8'd2;

	localparam logic [QUAL_W-1:0] GOOD_QUALITY = 7'd100;

	// Status codes of a result beat.
	localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_BUSY   = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_UNSYNC = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_BAD    = 2'd3;

	// Controller states: frame parsing phases followed by the channel burst.
	typedef enum logic [3:0] {
		ST_UNSYNCED,
		ST_HEADER,
		ST_STATUS,
		ST_DATA,
		ST_CHECK_HI,
		ST_SKIP_A,
		ST_SKIP_B,
		ST_CHECK_FINAL,
		ST_BURST_RD,
		ST_BURST_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                start_frame;
		logic                set_sum;
		logic                absorb;
		logic                load_count;
		logic                store_data;
		logic                load_check;
		logic                frame_good;
		logic                burst_rd;
		logic                burst_load;
		logic                emit;
		logic [STATUS_W-1:0] code;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic hdr_ok;
		logic id_ok;
		logic id_sum;
		logic count_ok;
		logic data_done;
		logic crc_mode;
		logic check_ok;
		logic burst_last;
		logic out_free;
	} stat_t;

	// One byte of CRC-16 with polynomial 0x1021, most significant bit first.
	function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	// The first four outputs come from packet channels 1, 2, 0, 3.
	function automatic logic [INDEX_W-1:0] src_of(input logic [INDEX_W-1:0] k);
		logic [INDEX_W-1:0] s;
		unique case (k)
			5'd0:    s = 5'd1;
			5'd1:    s = 5'd2;
			5'd2:    s = 5'd0;
			default: s = k;
		endcase
		return s;
	endfunction

endpackage

/* hw/rtl/rc_serial_frame_decoder.sv */
// Top level of the remote-control serial frame decoder.
// Depends on rsfd_pkg, rsfd_ctrl, rsfd_datapath and rsfd_ram.
//
// The decoder takes one received byte per input beat and frames packets that
// open with header 0xA8, a variant byte (0x01 for CRC-16, 0x00 for an 8-bit
// sum with three skipped bytes), a channel count and two big-endian bytes per
// channel. Every byte that does not complete a good packet gives one status
// beat in the cycle after it is taken, and bytes are taken one per cycle while
// the output keeps draining. The last byte of a good packet gives one beat per
// reported channel instead; each channel beat needs a store read state and then
// a load state, because the byte store is read through registered ports, and
// the input is held for the whole burst. The store needs no clearing pass
// after reset: per-entry valid flags make unwritten entries read as zero.
module rc_serial_frame_decoder #(
	parameter int MAX_CHANNELS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: max_channels.
	input  logic        cfg_we,
	input  logic [5:0]  cfg_wdata,
	// Input beats. s_tdata: rx_byte [7:0].
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,
	// Result beats. m_tdata: channel_index [4:0], channel_value [17:5],
	// clamped frame count [23:18], frame_counter [31:24], signal_quality [38:32],
	// zero [39]. m_tuser: status [1:0].
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,
	output logic [1:0]  m_tuser,
	output logic        m_tlast
);
	import rsfd_pkg::*;

	cmd_t                cmd;
	stat_t               stat;
	logic [INDEX_W-1:0]  out_index;
	logic [VALUE_W-1:0]  out_value;
	logic [COUNT_W-1:0]  out_count;
	logic [FRAMES_W-1:0] out_frames;
	logic [QUAL_W-1:0]   out_quality;

	rsfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rsfd_datapath #(.MAX_CHANNELS(MAX_CHANNELS)) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.rx_byte     (s_tdata),
		.cmd         (cmd),
		.stat        (stat),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.out_status  (m_tuser),
		.out_index   (out_index),
		.out_value   (out_value),
		.out_count   (out_count),
		.out_frames  (out_frames),
		.out_quality (out_quality),
		.out_last    (m_tlast)
	);

	// Pack the result fields, lowest field first, padded to whole bytes.
	assign m_tdata = {1'b0, out_quality, out_frames, out_count, out_value, out_index};

endmodule

/* hw/rtl/rsfd_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used by the decoder datapath for the channel byte store.
module rsfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/rsfd_ctrl.sv */
// Controller state machine of the serial frame decoder: parses the packet
// phases and sequences the channel burst. Depends on rsfd_pkg.
module rsfd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  rsfd_pkg::stat_t stat,
	output rsfd_pkg::cmd_t  cmd
);
	import rsfd_pkg::*;

	state_t state_q, state_d;
	logic   accept;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_UNSYNCED;
		end else begin
			state_q <= state_d;
		end
	end

	// Input bytes are taken in every parsing phase while the result register can load.
	assign s_tready = stat.out_free && (state_q != ST_BURST_RD) && (state_q != ST_BURST_OUT);
	assign accept   = s_tvalid && s_tready;

	// Next state and datapath commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.code = STAT_BUSY;
		unique case (state_q)
			ST_UNSYNCED: begin
				if (accept) begin
					cmd.emit = 1'b1;
					if (stat.hdr_ok) begin
						cmd.start_frame = 1'b1;
						state_d         = ST_HEADER;
					end else begin
						cmd.code = STAT_UNSYNC;
					end
				end
			end
			ST_HEADER: begin
				if (accept) begin
					cmd.emit = 1'b1;
					if (stat.id_ok) begin
						cmd.set_sum = stat.id_sum;
						cmd.absorb  = 1'b1;
						state_d     = ST_STATUS;
					end else begin
						state_d = ST_UNSYNCED;
					end
				end
			end
			ST_STATUS: begin
				if (accept) begin
					cmd.emit = 1'b1;
					if (stat.count_ok) begin
						cmd.load_count = 1'b1;
						cmd.absorb     = 1'b1;
						state_d        = ST_DATA;
					end else begin
						state_d = ST_UNSYNCED;
					end
				end
			end
			ST_DATA: begin
				if (accept) begin
					cmd.emit       = 1'b1;
					cmd.store_data = 1'b1;
					cmd.absorb     = 1'b1;
					if (stat.data_done) begin
						state_d = ST_CHECK_HI;
					end
				end
			end
			ST_CHECK_HI: begin
				if (accept) begin
					cmd.emit       = 1'b1;
					cmd.load_check = 1'b1;
					state_d        = stat.crc_mode ? ST_CHECK_FINAL : ST_SKIP_A;
				end
			end
			ST_SKIP_A: begin
				if (accept) begin
					cmd.emit = 1'b1;
					state_d  = ST_SKIP_B;
				end
			end
			ST_SKIP_B: begin
				if (accept) begin
					cmd.emit = 1'b1;
					state_d  = ST_CHECK_FINAL;
				end
			end
			ST_CHECK_FINAL: begin
				if (accept) begin
					if (stat.check_ok) begin
						cmd.frame_good = 1'b1;
						state_d        = ST_BURST_RD;
					end else begin
						cmd.emit = 1'b1;
						cmd.code = STAT_BAD;
						state_d  = ST_UNSYNCED;
					end
				end
			end
			ST_BURST_RD: begin
				cmd.burst_rd = 1'b1;
				state_d      = ST_BURST_OUT;
			end
			ST_BURST_OUT: begin
				if (stat.out_free) begin
					cmd.burst_load = 1'b1;
					state_d        = stat.burst_last ? ST_UNSYNCED : ST_BURST_RD;
				end
			end
			default: begin
				state_d = ST_UNSYNCED;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	// A good frame always starts a burst that reads before it loads a beat.
	a_good_starts_burst: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.frame_good |=> cmd.burst_rd)
		else $error("good frame did not start a channel burst");

	// A channel beat is loaded right after its store read, or later if the output stalls.
	a_load_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.burst_load |-> $past(cmd.burst_rd) || $past(state_q == ST_BURST_OUT))
		else $error("channel beat loaded without a store read");

	// No input byte is taken while a burst is running.
	a_no_input_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.burst_rd || cmd.burst_load) |-> !accept)
		else $error("input accepted during channel burst");
`endif

endmodule

/* hw/rtl/rsfd_datapath.sv */
// Datapath of the serial frame decoder: running CRC and sum, byte store,
// frame counters and the result register. Depends on rsfd_pkg and rsfd_ram.
module rsfd_datapath #(
	parameter int MAX_CHANNELS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [rsfd_pkg::COUNT_W-1:0]       cfg_wdata,
	input  logic [7:0]                         rx_byte,
	input  rsfd_pkg::cmd_t                     cmd,
	output rsfd_pkg::stat_t                    stat,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic [rsfd_pkg::STATUS_W-1:0]      out_status,
	output logic [rsfd_pkg::INDEX_W-1:0]       out_index,
	output logic [rsfd_pkg::VALUE_W-1:0]       out_value,
	output logic [rsfd_pkg::COUNT_W-1:0]       out_count,
	output logic [rsfd_pkg::FRAMES_W-1:0]      out_frames,
	output logic [rsfd_pkg::QUAL_W-1:0]        out_quality,
	output logic                               out_last
);
	import rsfd_pkg::*;

	localparam int AW = $clog2(MAX_CHANNELS);
	localparam logic [7:0] MaxByte = 8'(MAX_CHANNELS);
	localparam logic [COUNT_W-1:0] MaxCount = COUNT_W'(MAX_CHANNELS);
	localparam logic [BCNT_W-1:0] StoreDepth = BCNT_W'(2 * MAX_CHANNELS);

	// Frame state.
	logic                crc_mode_q;
	logic [15:0]         crc_q;
	logic [7:0]          sum_q;
	logic [BCNT_W-1:0]   byte_count_q;
	logic [COUNT_W-1:0]  fc_q;
	logic [7:0]          chk_hi_q;
	logic [FRAMES_W-1:0] good_frames_q;
	logic [COUNT_W-1:0]  max_ch_q;

	// Burst state.
	logic [COUNT_W-1:0]  burst_cnt_q;
	logic [INDEX_W-1:0]  k_q;
	logic                hv_q, lv_q;

	// Byte store: even bytes in one RAM, odd bytes in the other.
	logic [MAX_CHANNELS-1:0] hi_vld_q, lo_vld_q;
	logic [AW-1:0]           waddr, raddr;
	logic [INDEX_W-1:0]      src;
	logic                    we_hi, we_lo;
	logic [7:0]              hi_rd, lo_rd;
	logic [15:0]             word;
	logic                    eff_crc;
	logic [COUNT_W-1:0]      limit, clamp;

	assign waddr = byte_count_q[AW:1];
	assign we_hi = cmd.store_data && !byte_count_q[0];
	assign we_lo = cmd.store_data && byte_count_q[0];
	assign src   = src_of(k_q);
	assign raddr = src[AW-1:0];

	rsfd_ram #(.WIDTH(8), .DEPTH(MAX_CHANNELS)) u_store_hi (
		.clk   (clk),
		.we    (we_hi),
		.waddr (waddr),
		.wdata (rx_byte),
		.re    (cmd.burst_rd),
		.raddr (raddr),
		.rdata (hi_rd)
	);

	rsfd_ram #(.WIDTH(8), .DEPTH(MAX_CHANNELS)) u_store_lo (
		.clk   (clk),
		.we    (we_lo),
		.waddr (waddr),
		.wdata (rx_byte),
		.re    (cmd.burst_rd),
		.raddr (raddr),
		.rdata (lo_rd)
	);

	// A store entry never written reads as zero.
	assign word = {hv_q ? hi_rd : 8'h00, lv_q ? lo_rd : 8'h00};

	// Check variant in force for this byte; the sum flag applies at once.
	assign eff_crc = cmd.set_sum ? 1'b0 : crc_mode_q;

	// Reported count: frame count clamped to the register, zero meaning one.
	assign limit = (max_ch_q == '0) ? COUNT_W'(1) : max_ch_q;
	assign clamp = (fc_q > limit) ? limit : fc_q;

	// Status toward the controller.
	always_comb begin
		stat.hdr_ok     = (rx_byte == HDR_BYTE);
		stat.id_ok      = (rx_byte == ID_CRC) || (rx_byte == ID_SUM);
		stat.id_sum     = (rx_byte == ID_SUM);
		stat.count_ok   = (rx_byte >= MIN_COUNT) && (rx_byte <= MaxByte);
		stat.data_done  = ((byte_count_q + BCNT_W'(1)) >= {fc_q, 1'b0});
		stat.crc_mode   = crc_mode_q;
		stat.check_ok   = crc_mode_q ? (crc_q == {chk_hi_q, rx_byte}) : (sum_q == rx_byte);
		stat.burst_last = ({1'b0, k_q} + COUNT_W'(1)) == burst_cnt_q;
		stat.out_free   = !out_valid || out_ready;
	end

	// Control registers with defined reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_ch_q      <= MaxCount;
			good_frames_q <= '0;
			hi_vld_q      <= '0;
			lo_vld_q      <= '0;
			out_valid     <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_ch_q <= cfg_wdata;
			end
			if (cmd.frame_good) begin
				good_frames_q <= good_frames_q + FRAMES_W'(1);
			end
			if (we_hi) begin
				hi_vld_q[waddr] <= 1'b1;
			end
			if (we_lo) begin
				lo_vld_q[waddr] <= 1'b1;
			end
			if (cmd.emit || cmd.burst_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Running check and frame bookkeeping.
	always_ff @(posedge clk) begin
		if (cmd.start_frame) begin
			crc_mode_q   <= 1'b1;
			crc_q        <= crc_add(16'h0000, rx_byte);
			sum_q        <= rx_byte;
			byte_count_q <= '0;
		end else begin
			if (cmd.set_sum) begin
				crc_mode_q <= 1'b0;
			end
			if (cmd.absorb && eff_crc) begin
				crc_q <= crc_add(crc_q, rx_byte);
			end
			if (cmd.absorb && !eff_crc) begin
				sum_q <= sum_q + rx_byte;
			end
			if (cmd.store_data) begin
				byte_count_q <= byte_count_q + BCNT_W'(1);
			end
		end
		if (cmd.load_count) begin
			fc_q <= rx_byte[COUNT_W-1:0];
		end
		if (cmd.load_check) begin
			chk_hi_q <= rx_byte;
		end
	end

	// Burst sequencing: count latch, channel index and entry valid flags.
	always_ff @(posedge clk) begin
		if (cmd.frame_good) begin
			burst_cnt_q <= clamp;
			k_q         <= '0;
		end else if (cmd.burst_load) begin
			k_q <= k_q + INDEX_W'(1);
		end
		if (cmd.burst_rd) begin
			hv_q <= hi_vld_q[raddr];
			lv_q <= lo_vld_q[raddr];
		end
	end

	// Result register: status beat or channel beat.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_status  <= cmd.code;
			out_index   <= '0;
			out_value   <= '0;
			out_count   <= '0;
			out_frames  <= good_frames_q;
			out_quality <= '0;
			out_last    <= 1'b1;
		end else if (cmd.burst_load) begin
			out_status  <= STAT_OK;
			out_index   <= k_q;
			out_value   <= word[15:3];
			out_count   <= burst_cnt_q;
			out_frames  <= good_frames_q;
			out_quality <= GOOD_QUALITY;
			out_last    <= stat.burst_last;
		end
	end

`ifndef NO_ASSERTIONS
	// Data bytes always land inside the store.
	a_store_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store_data |-> byte_count_q < StoreDepth)
		else $error("data byte beyond store depth");

	// A burst reads only channels below a legal, nonzero count.
	a_burst_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.burst_rd |-> ({1'b0, k_q} < burst_cnt_q) && (burst_cnt_q <= MaxCount))
		else $error("burst index or count out of range");

	// A channel beat carries full quality and a nonzero count.
	a_ok_beat_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_status == STAT_OK) |->
			(out_quality == GOOD_QUALITY) && (out_count != '0))
		else $error("channel beat with bad quality or count");

	// Status and channel beats are never loaded together.
	a_single_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !cmd.burst_load && !cmd.frame_good)
		else $error("conflicting result loads");
`endif

endmodule

/* dv/rc_serial_frame_decoder_test.sv */
// Self-checking testbench for rc_serial_frame_decoder: drives received bytes,
// predicts every status and channel beat, and compares the result stream.
// Depends on rsfd_pkg and the rc_serial_frame_decoder RTL.
module rc_serial_frame_decoder_test;
	import rsfd_pkg::*;

	localparam int MAX_CH = 32;
	localparam int STORE_DEPTH = 2 * MAX_CH;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [INDEX_W-1:0] FIRST_FOUR [4] = '{5'd1, 5'd2, 5'd0, 5'd3};

	// One result beat split into its fields.
	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [INDEX_W-1:0]  index;
		logic [VALUE_W-1:0]  value;
		logic [COUNT_W-1:0]  count;
		logic [FRAMES_W-1:0] frames;
		logic [QUAL_W-1:0]   quality;
		logic                pad;
		logic                last;
	} result_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [5:0]  cfg_wdata = 6'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	// Bytes waiting to be sent and beats the decoder still owes.
	logic [7:0]   tx_bytes[$];
	result_beat_t predicted_beats[$];

	// Shadow copy of the decoder state.
	state_t      frame_phase;
	bit          crc_mode;
	logic [15:0] crc_acc;
	logic [7:0]  sum_acc;
	int          data_len;
	int          frame_ch;
	logic [7:0]  byte_store [STORE_DEPTH];
	logic [7:0]  chk_hi;
	logic [7:0]  chk_lo;
	logic [7:0]  good_count;
	logic [5:0]  channel_limit;

	// Run bookkeeping.
	int  mismatches = 0;
	int  bytes_sent = 0;
	int  beats_seen = 0;
	int  frames_ok = 0;
	int  frames_failed = 0;
	int  queued = 0;
	int  cycles = 0;
	bit  beat_taken = 1'b0;
	bit  sender_steady = 1'b0;
	bit  receiver_steady = 1'b0;
	int  burst_left = 0;
	int  gap_left = 0;
	int  hold_asks = 0;
	int  holds_served = 0;
	int  hold_left = 0;
	int  ready_cycle = 0;
	logic [15:0] ready_pattern = 16'hFFFF;

	rc_serial_frame_decoder #(
		.MAX_CHANNELS(MAX_CH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	// Free-running clock with a period of two time units.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// A run that hangs ends here.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats still owed", cycles,
				predicted_beats.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// CRC-16 with polynomial 0x1021, one byte, most significant bit first.
	function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] r;
		r = acc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (r[15])
				r = (r << 1) ^ 16'h1021;
			else
				r = r << 1;
		end
		return r;
	endfunction

	task automatic clear_decoder_state();
		frame_phase = ST_UNSYNCED;
		crc_mode = 1'b1;
		crc_acc = '0;
		sum_acc = '0;
		data_len = 0;
		frame_ch = 0;
		foreach (byte_store[i])
			byte_store[i] = '0;
		chk_hi = '0;
		chk_lo = '0;
		good_count = '0;
		channel_limit = 6'd32;
	endtask

	task automatic owe_status(input logic [STATUS_W-1:0] st);
		result_beat_t r;
		r.status = st;
		r.index = '0;
		r.value = '0;
		r.count = '0;
		r.frames = good_count;
		r.quality = '0;
		r.pad = 1'b0;
		r.last = 1'b1;
		predicted_beats.push_back(r);
	endtask

	task automatic fold_byte(input logic [7:0] b);
		if (crc_mode)
			crc_acc = crc16_byte(crc_acc, b);
		else
			sum_acc = sum_acc + b;
	endtask

	// Advance the shadow decoder by one byte and queue the beats it causes.
	task automatic decode_byte(input logic [7:0] b);
		bit ok;
		int lim;
		int cnt;
		int src;
		result_beat_t r;
		case (frame_phase)
			ST_UNSYNCED: begin
				if (b != HDR_BYTE) begin
					owe_status(STAT_UNSYNC);
				end else begin
					crc_mode = 1'b1;
					data_len = 0;
					crc_acc = crc16_byte(16'h0000, b);
					sum_acc = b;
					frame_phase = ST_HEADER;
					owe_status(STAT_BUSY);
				end
			end
			ST_HEADER: begin
				if (b == ID_CRC || b == ID_SUM) begin
					if (b == ID_SUM)
						crc_mode = 1'b0;
					fold_byte(b);
					frame_phase = ST_STATUS;
				end else begin
					frame_phase = ST_UNSYNCED;
				end
				owe_status(STAT_BUSY);
			end
			ST_STATUS: begin
				if (b >= MIN_COUNT && b <= MAX_CH) begin
					frame_ch = b;
					fold_byte(b);
					frame_phase = ST_DATA;
				end else begin
					frame_phase = ST_UNSYNCED;
				end
				owe_status(STAT_BUSY);
			end
			ST_DATA: begin
				if (data_len < STORE_DEPTH)
					byte_store[data_len] = b;
				fold_byte(b);
				data_len = (data_len + 1) & 8'h7F;
				if (data_len >= 2 * frame_ch)
					frame_phase = ST_CHECK_HI;
				owe_status(STAT_BUSY);
			end
			ST_CHECK_HI: begin
				chk_hi = b;
				frame_phase = crc_mode ? ST_CHECK_FINAL : ST_SKIP_A;
				owe_status(STAT_BUSY);
			end
			ST_SKIP_A: begin
				chk_lo = b;
				frame_phase = ST_SKIP_B;
				owe_status(STAT_BUSY);
			end
			ST_SKIP_B: begin
				frame_phase = ST_CHECK_FINAL;
				owe_status(STAT_BUSY);
			end
			default: begin
				// Final check byte: a good frame turns into a burst of channels.
				frame_phase = ST_UNSYNCED;
				if (crc_mode) begin
					chk_lo = b;
					ok = (crc_acc == {chk_hi, b});
				end else begin
					ok = (sum_acc == b);
				end
				if (!ok) begin
					owe_status(STAT_BAD);
				end else begin
					good_count = good_count + 1'b1;
					lim = (channel_limit == 0) ? 1 : channel_limit;
					cnt = (frame_ch > lim) ? lim : frame_ch;
					if (cnt > MAX_CH)
						cnt = MAX_CH;
					for (int k = 0; k < cnt; k++) begin
						src = (k < 4) ? FIRST_FOUR[k] : k;
						r.status = STAT_OK;
						r.index = k[INDEX_W-1:0];
						r.value = VALUE_W'({byte_store[2 * src], byte_store[2 * src + 1]} >> 3);
						r.count = cnt[COUNT_W-1:0];
						r.frames = good_count;
						r.quality = GOOD_QUALITY;
						r.pad = 1'b0;
						r.last = (k + 1 == cnt);
						predicted_beats.push_back(r);
					end
				end
			end
		endcase
	endtask

	task automatic count_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%s", msg);
	endtask

	// Compare one received result beat against the oldest prediction.
	task automatic check_beat();
		result_beat_t seen;
		result_beat_t want;
		seen.status = m_tuser;
		seen.index = m_tdata[4:0];
		seen.value = m_tdata[17:5];
		seen.count = m_tdata[23:18];
		seen.frames = m_tdata[31:24];
		seen.quality = m_tdata[38:32];
		seen.pad = m_tdata[39];
		seen.last = m_tlast;
		beats_seen++;
		if (seen.status == STAT_OK && seen.last)
			frames_ok++;
		if (seen.status == STAT_BAD)
			frames_failed++;
		if (predicted_beats.size() == 0) begin
			count_mismatch($sformatf("beat %0d arrived with nothing expected: st=%0d tdata=%h",
				beats_seen, seen.status, m_tdata));
		end else begin
			want = predicted_beats.pop_front();
			if (seen.status !== want.status || seen.index !== want.index ||
					seen.value !== want.value || seen.count !== want.count ||
					seen.frames !== want.frames || seen.quality !== want.quality ||
					seen.pad !== want.pad || seen.last !== want.last)
				count_mismatch($sformatf({"beat %0d mismatch: expected st=%0d idx=%0d val=%0d ",
					"cnt=%0d frm=%0d q=%0d pad=%0d last=%0d, got st=%0d idx=%0d val=%0d ",
					"cnt=%0d frm=%0d q=%0d pad=%0d last=%0d"}, beats_seen,
					want.status, want.index, want.value, want.count, want.frames,
					want.quality, want.pad, want.last, seen.status, seen.index,
					seen.value, seen.count, seen.frames, seen.quality, seen.pad,
					seen.last));
		end
	endtask

	// Monitor: check result beats first, then predict from the accepted byte.
	always @(posedge clk) begin
		if (!arst_n) begin
			beat_taken <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				check_beat();
			beat_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				decode_byte(s_tdata);
				void'(tx_bytes.pop_front());
				bytes_sent++;
			end
		end
	end

	// Driver: offers queued bytes in bursts separated by random gaps.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (s_tvalid && !beat_taken) begin
			s_tvalid <= 1'b1;
		end else if (gap_left > 0 && !sender_steady) begin
			gap_left--;
			s_tvalid <= 1'b0;
		end else if (tx_bytes.size() == 0) begin
			s_tvalid <= 1'b0;
		end else begin
			s_tvalid <= 1'b1;
			s_tdata <= tx_bytes[0];
			if (burst_left <= 1) begin
				burst_left = $urandom_range(1, 24);
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			end else begin
				burst_left--;
			end
		end
	end

	// Receiver: stalls on a rotating pattern, or holds off for a long stretch on request.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (hold_asks != holds_served) begin
				holds_served = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (ready_cycle % 48 == 0)
				ready_pattern = 16'($urandom) | 16'h0421;
			ready_cycle++;
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (receiver_steady) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ready_pattern[0];
				ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
			end
		end
	end

	function automatic logic [7:0] data_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			2: return HDR_BYTE;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic int pick_channels();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(2, 6);
		if (r < 95)
			return $urandom_range(7, 16);
		return MAX_CH;
	endfunction

	task automatic queue_byte(input logic [7:0] b);
		tx_bytes.push_back(b);
		queued++;
	endtask

	// Build one packet; damage 1 flips a bit after the count, damage 2 cuts it short.
	task automatic queue_frame(input bit use_crc, input int nch, input int damage);
		logic [7:0]  fr[$];
		logic [15:0] crc;
		logic [7:0]  sum;
		int pos;
		fr.push_back(HDR_BYTE);
		fr.push_back(use_crc ? ID_CRC : ID_SUM);
		fr.push_back(8'(nch));
		repeat (2 * nch)
			fr.push_back(data_byte());
		crc = '0;
		sum = '0;
		foreach (fr[i]) begin
			crc = crc16_byte(crc, fr[i]);
			sum = sum + fr[i];
		end
		if (use_crc) begin
			fr.push_back(crc[15:8]);
			fr.push_back(crc[7:0]);
		end else begin
			repeat (3)
				fr.push_back(data_byte());
			fr.push_back(sum);
		end
		if (damage == 1) begin
			pos = $urandom_range(3, fr.size() - 1);
			fr[pos] = fr[pos] ^ (8'h01 << $urandom_range(0, 7));
		end else if (damage == 2) begin
			repeat ($urandom_range(1, fr.size() - 3))
				void'(fr.pop_back());
		end
		foreach (fr[i])
			queue_byte(fr[i]);
	endtask

	// Line noise: stray bytes, or a header followed by a bad variant or count.
	task automatic queue_noise();
		logic [7:0] bad_count [5] = '{8'd0, 8'd1, 8'd33, 8'hFF, 8'hA8};
		case ($urandom_range(0, 2))
			0: repeat ($urandom_range(1, 3)) queue_byte(8'($urandom));
			1: begin
				queue_byte(HDR_BYTE);
				queue_byte(8'($urandom_range(2, 255)));
			end
			default: begin
				queue_byte(HDR_BYTE);
				queue_byte($urandom_range(0, 1) ? ID_CRC : ID_SUM);
				queue_byte(bad_count[$urandom_range(0, 4)]);
			end
		endcase
	endtask

	// Mostly well-formed packets with random content, the rest damaged or noise.
	task automatic queue_random(input int n);
		int start;
		int r;
		start = queued;
		while (queued - start < n) begin
			r = $urandom_range(0, 99);
			if (r < 68)
				queue_frame($urandom_range(0, 1), pick_channels(), 0);
			else if (r < 80)
				queue_frame($urandom_range(0, 1), pick_channels(), 1);
			else if (r < 88)
				queue_frame($urandom_range(0, 1), pick_channels(), 2);
			else
				queue_noise();
		end
	endtask

	// Wait until every byte is taken and every predicted beat has arrived.
	task automatic wait_idle();
		while (tx_bytes.size() != 0 || predicted_beats.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_channel_limit(input logic [5:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		channel_limit = v;
	endtask

	// Test sequence: directed corner cases, then random phases at several limits.
	initial begin
		clear_decoder_state();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Byte extremes, a repeated header, bad variant and bad counts, a short sum frame.
		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_byte(HDR_BYTE);
		queue_byte(HDR_BYTE);
		queue_byte(HDR_BYTE);
		queue_byte(8'hFF);
		queue_byte(HDR_BYTE);
		queue_byte(ID_CRC);
		queue_byte(8'd1);
		queue_byte(HDR_BYTE);
		queue_byte(ID_SUM);
		queue_byte(8'd33);
		queue_frame(1'b0, 2, 0);
		wait_idle();

		// Reset limit, random stalls on both sides.
		queue_random(22);
		wait_idle();

		// Smallest limit: one channel per good frame.
		write_channel_limit(6'd1);
		queue_random(18);
		wait_idle();

		// A zero limit acts as one; no idling on either side here.
		write_channel_limit(6'd0);
		sender_steady = 1'b1;
		receiver_steady = 1'b1;
		queue_random(14);
		wait_idle();
		sender_steady = 1'b0;
		receiver_steady = 1'b0;

		// Limit above any count, a full-size packet, and a long receiver hold-off.
		write_channel_limit(6'd63);
		queue_frame(1'b1, MAX_CH, 0);
		queue_random(6);
		hold_asks++;
		wait_idle();

		// Limit of three: short frames read stale store entries through the reorder.
		write_channel_limit(6'd3);
		queue_random(14);
		wait_idle();

		write_channel_limit(6'($urandom_range(1, 32)));
		queue_random(14);
		wait_idle();

		write_channel_limit(6'd32);
		queue_random(12);
		wait_idle();

		repeat (20) @(posedge clk);
		if (predicted_beats.size() != 0)
			count_mismatch($sformatf("%0d expected beats never arrived",
				predicted_beats.size()));
		$display("Sent %0d bytes and checked %0d result beats over seven channel limits.",
			bytes_sent, beats_seen);
		$display("Saw %0d good frames and %0d failed checks; %0d mismatches.",
			frames_ok, frames_failed, mismatches);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

/* rc_serial_frame_decoder.f */
hw/rtl/rsfd_pkg.sv
hw/rtl/rsfd_ram.sv
hw/rtl/rsfd_ctrl.sv
hw/rtl/rsfd_datapath.sv
hw/rtl/rc_serial_frame_decoder.sv
dv/rc_serial_frame_decoder_test.sv
